// ===== sv/tbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_pkg
// shared types, stream widths and 2-bit counter helpers for the predictor
// ----------------------------------------------------------------------------
package tbp_pkg;

	// stream payload widths, fixed by the field layout
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 8;
	localparam int PC_W        = 32;

	// field positions in the input and output tdata
	localparam int IN_TAKEN_BIT     = 32;
	localparam int OUT_PRED_BIT     = 0;
	localparam int OUT_CHOSE_G_BIT  = 1;

	typedef logic [1:0] ctr_t;

	localparam ctr_t CTR_STRONG_NT = 2'd0;
	localparam ctr_t CTR_WEAK_NT   = 2'd1;
	localparam ctr_t CTR_STRONG_T  = 2'd3;

	// global counter in the low half, choice counter in the high half
	typedef struct packed {
		ctr_t choice;
		ctr_t glob;
	} gc_entry_t;

	function automatic ctr_t ctr_train(input ctr_t c, input logic up);
		ctr_t r;
		r = c;
		if (up) begin
			if (c != CTR_STRONG_T) r = c + 2'd1;
		end else begin
			if (c != CTR_STRONG_NT) r = c - 2'd1;
		end
		return r;
	endfunction

	function automatic logic ctr_pred(input ctr_t c);
		return c[1];
	endfunction

endpackage

// ===== sv/tbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbp_ram
// simple dual-port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
module tbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/tournament_branch_predictor_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core
// tournament predictor: per-pc local history, global history, choice counters
// ----------------------------------------------------------------------------
// Takes one resolved conditional branch per transfer (pc and outcome), returns
// the prediction held before training plus which component the choice counter
// picked, then trains all tables. One branch per clock is sustained while the
// output is not stalled; results pass the stage 1 and stage 2 registers into
// the output register. The pipeline has three steps: local history read, then
// local counter plus global/choice counter read, then prediction and
// write-back; each table is a synchronous ram with a registered read, and a
// one-entry bypass per table covers the write of the branch just ahead. After
// reset a clearing pass writes reset values to 2**max(GLOBAL_HISTORY_BITS,
// LOCAL_INDEX_BITS, LOCAL_HISTORY_BITS) addresses (4096 with the defaults);
// s_axis_tready stays low until it ends. A stalled output freezes the pipeline.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core
	import tbp_pkg::*;
#(
	parameter int GLOBAL_HISTORY_BITS = 12,
	parameter int LOCAL_INDEX_BITS    = 10,
	parameter int LOCAL_HISTORY_BITS  = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [31:0] branch_pc, [32] taken, [39:33] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [0] predicted_taken, [1] chose_global, [7:2] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int GH = GLOBAL_HISTORY_BITS;
	localparam int LI = LOCAL_INDEX_BITS;
	localparam int LH = LOCAL_HISTORY_BITS;
	localparam int CLR_W_A = (GH > LI) ? GH : LI;
	localparam int CLR_W   = (CLR_W_A > LH) ? CLR_W_A : LH;

	// clearing pass
	logic [CLR_W-1:0] clr_q;
	logic             clr_done_q;
	logic             clearing;

	// global history
	logic [GH-1:0] gh_q;

	// pipeline control
	logic adv;
	logic in_xfer;

	// stage 1: local history arrives
	logic          v_s1;
	logic [LI-1:0] li_s1;
	logic [GH-1:0] gi_s1;
	logic          taken_s1;

	// stage 2: counters arrive
	logic          v_s2;
	logic [LH-1:0] lh_s2;
	logic [GH-1:0] gi_s2;
	logic          taken_s2;

	// output register
	logic out_v_q;
	logic pred_q;
	logic chose_g_q;

	// bypass of the latest write per table
	logic          lht_fw_v_q;
	logic [LI-1:0] lht_fw_addr_q;
	logic [LH-1:0] lht_fw_data_q;
	logic          lc_fw_v_q;
	logic [LH-1:0] lc_fw_addr_q;
	ctr_t          lc_fw_data_q;
	logic          gc_fw_v_q;
	logic [GH-1:0] gc_fw_addr_q;
	gc_entry_t     gc_fw_data_q;

	// ram ports
	logic          lht_we;
	logic [LI-1:0] lht_waddr;
	logic [LH-1:0] lht_wdata;
	logic [LH-1:0] lht_rdata;
	logic          lc_we;
	logic [LH-1:0] lc_waddr;
	ctr_t          lc_wdata;
	ctr_t          lc_rdata;
	logic          gc_we;
	logic [GH-1:0] gc_waddr;
	gc_entry_t     gc_wdata;
	gc_entry_t     gc_rdata;

	// stage values
	logic [LH-1:0] lh_s1;
	logic [LH-1:0] lh_new_s1;
	ctr_t          lc_s2;
	gc_entry_t     gc_s2;
	logic          local_pred_s2;
	logic          global_pred_s2;
	logic          use_global_s2;
	ctr_t          lc_new_s2;
	gc_entry_t     gc_new_s2;

	assign clearing      = !clr_done_q;
	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = adv && clr_done_q;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// clearing pass, one entry of every table per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == {CLR_W{1'b1}}) clr_done_q <= 1'b1;
		end
	end

	// global history moves at the input transfer, so the next branch sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gh_q <= '0;
		end else if (in_xfer) begin
			gh_q <= {gh_q[GH-2:0], s_axis_tdata[IN_TAKEN_BIT]};
		end
	end

	// ---------------- stage 1: local history and its update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			li_s1    <= s_axis_tdata[LI-1:0];
			gi_s1    <= gh_q;
			taken_s1 <= s_axis_tdata[IN_TAKEN_BIT];
		end
	end

	// the branch just ahead may have written this pc's history
	assign lh_s1     = (lht_fw_v_q && lht_fw_addr_q == li_s1) ? lht_fw_data_q : lht_rdata;
	assign lh_new_s1 = {lh_s1[LH-2:0], taken_s1};

	always_comb begin
		if (clearing) begin
			lht_we    = 1'b1;
			lht_waddr = clr_q[LI-1:0];
			lht_wdata = '0;
		end else begin
			lht_we    = adv && v_s1;
			lht_waddr = li_s1;
			lht_wdata = lh_new_s1;
		end
	end

	// ---------------- stage 2: counters, prediction, training ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lh_s2    <= lh_s1;
			gi_s2    <= gi_s1;
			taken_s2 <= taken_s1;
		end
	end

	assign lc_s2 = (lc_fw_v_q && lc_fw_addr_q == lh_s2) ? lc_fw_data_q : lc_rdata;
	assign gc_s2 = (gc_fw_v_q && gc_fw_addr_q == gi_s2) ? gc_fw_data_q : gc_rdata;

	assign local_pred_s2  = ctr_pred(lc_s2);
	assign global_pred_s2 = ctr_pred(gc_s2.glob);
	assign use_global_s2  = ctr_pred(gc_s2.choice);

	always_comb begin
		lc_new_s2        = ctr_train(lc_s2, taken_s2);
		gc_new_s2.glob   = ctr_train(gc_s2.glob, taken_s2);
		gc_new_s2.choice = gc_s2.choice;
		// choice only learns when the components disagree
		if (local_pred_s2 != global_pred_s2) begin
			gc_new_s2.choice = ctr_train(gc_s2.choice, global_pred_s2 == taken_s2);
		end
	end

	always_comb begin
		if (clearing) begin
			lc_we         = 1'b1;
			lc_waddr      = clr_q[LH-1:0];
			lc_wdata      = CTR_WEAK_NT;
			gc_we         = 1'b1;
			gc_waddr      = clr_q[GH-1:0];
			gc_wdata      = '{choice: CTR_WEAK_NT, glob: CTR_WEAK_NT};
		end else begin
			lc_we         = adv && v_s2;
			lc_waddr      = lh_s2;
			lc_wdata      = lc_new_s2;
			gc_we         = adv && v_s2;
			gc_waddr      = gi_s2;
			gc_wdata      = gc_new_s2;
		end
	end

	// bypass registers follow the pipeline writes only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lht_fw_v_q <= 1'b0;
			lc_fw_v_q  <= 1'b0;
			gc_fw_v_q  <= 1'b0;
		end else if (adv) begin
			lht_fw_v_q <= v_s1;
			lc_fw_v_q  <= v_s2;
			gc_fw_v_q  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lht_fw_addr_q <= li_s1;
			lht_fw_data_q <= lh_new_s1;
			lc_fw_addr_q  <= lh_s2;
			lc_fw_data_q  <= lc_new_s2;
			gc_fw_addr_q  <= gi_s2;
			gc_fw_data_q  <= gc_new_s2;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			pred_q    <= use_global_s2 ? global_pred_s2 : local_pred_s2;
			chose_g_q <= use_global_s2;
		end
	end

	assign m_axis_tvalid = out_v_q;

	always_comb begin
		m_axis_tdata                  = '0;
		m_axis_tdata[OUT_PRED_BIT]    = pred_q;
		m_axis_tdata[OUT_CHOSE_G_BIT] = chose_g_q;
	end

	// ---------------- tables ----------------
	// local history per pc, read at the input transfer
	tbp_ram #(
		.WIDTH (LH),
		.DEPTH (2 ** LI)
	) u_lht (
		.clk   (clk),
		.we    (lht_we),
		.waddr (lht_waddr),
		.wdata (lht_wdata),
		.re    (adv),
		.raddr (s_axis_tdata[LI-1:0]),
		.rdata (lht_rdata)
	);

	// local counters indexed by local history
	tbp_ram #(
		.WIDTH ($bits(ctr_t)),
		.DEPTH (2 ** LH)
	) u_lc (
		.clk   (clk),
		.we    (lc_we),
		.waddr (lc_waddr),
		.wdata (lc_wdata),
		.re    (adv),
		.raddr (lh_s1),
		.rdata (lc_rdata)
	);

	// global and choice counters share the global history index
	tbp_ram #(
		.WIDTH ($bits(gc_entry_t)),
		.DEPTH (2 ** GH)
	) u_gc (
		.clk   (clk),
		.we    (gc_we),
		.waddr (gc_waddr),
		.wdata (gc_wdata),
		.re    (adv),
		.raddr (gi_s1),
		.rdata (gc_rdata)
	);

	// ---------------- assertions ----------------
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_axis_tready)
		else $error("input accepted during clearing pass");

	a_clear_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		clr_done_q |=> clr_done_q)
		else $error("clearing pass restarted");

	a_pipe_empty_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!v_s1 && !v_s2 && !out_v_q))
		else $error("pipeline busy during clearing pass");

	a_result_from_stage2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(v_s2))
		else $error("result appeared without a stage 2 item");

	a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s1) && $stable(v_s2) && $stable(gh_q)))
		else $error("pipeline moved while output stalled");

endmodule

// ===== bench/tournament_branch_predictor_core_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core_chk
// scoreboard for the tournament predictor stream
// ----------------------------------------------------------------------------
// Watches both stream sides. Each input transfer runs through a local model
// of the local, global and choice tables, which yields the prediction held
// before training; that is queued and compared field by field with the next
// output transfer. Mismatches are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core_chk
	import tbp_pkg::*;
#(
	parameter int GHB = 12,
	parameter int LIB = 10,
	parameter int LHB = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output int                     mismatches,
	output int                     outstanding
);

	typedef struct packed {
		logic chose_global;
		logic predicted_taken;
	} verdict_t;

	logic [LHB-1:0] hist_by_pc [2**LIB];
	ctr_t           local_ctr  [2**LHB];
	ctr_t           global_ctr [2**GHB];
	ctr_t           choice_ctr [2**GHB];
	logic [GHB-1:0] path_hist;
	verdict_t       predictions_due [$];

	function automatic ctr_t nudge(input ctr_t c, input logic up);
		if (up) return (c == CTR_STRONG_T) ? c : c + 2'd1;
		return (c == CTR_STRONG_NT) ? c : c - 2'd1;
	endfunction

	function automatic void clear_tables();
		foreach (hist_by_pc[i]) hist_by_pc[i] = '0;
		foreach (local_ctr[i]) local_ctr[i] = CTR_WEAK_NT;
		foreach (global_ctr[i]) global_ctr[i] = CTR_WEAK_NT;
		foreach (choice_ctr[i]) choice_ctr[i] = CTR_WEAK_NT;
		path_hist = '0;
		predictions_due.delete();
		mismatches = 0;
	endfunction

	// prediction from the tables as they stand, then training on the outcome
	function automatic verdict_t predict_branch(input logic [PC_W-1:0] pc, input logic tk);
		logic [LIB-1:0] slot;
		logic [LHB-1:0] lh;
		logic [GHB-1:0] gh;
		logic           lp, gp, ug;
		verdict_t       v;
		slot = pc[LIB-1:0];
		lh = hist_by_pc[slot];
		gh = path_hist;
		lp = (local_ctr[lh] >= 2'd2);
		gp = (global_ctr[gh] >= 2'd2);
		ug = (choice_ctr[gh] >= 2'd2);
		v.chose_global = ug;
		v.predicted_taken = ug ? gp : lp;
		if (lp != gp) choice_ctr[gh] = nudge(choice_ctr[gh], gp == tk);
		local_ctr[lh] = nudge(local_ctr[lh], tk);
		hist_by_pc[slot] = {lh[LHB-2:0], tk};
		global_ctr[gh] = nudge(global_ctr[gh], tk);
		path_hist = {gh[GHB-2:0], tk};
		return v;
	endfunction

	always @(posedge clk) begin
		verdict_t got, want;
		if (!arst_n) begin
			clear_tables();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predictions_due.push_back(predict_branch(s_axis_tdata[PC_W-1:0],
					s_axis_tdata[IN_TAKEN_BIT]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.predicted_taken = m_axis_tdata[OUT_PRED_BIT];
				got.chose_global = m_axis_tdata[OUT_CHOSE_G_BIT];
				if (predictions_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual pred=%b global=%b",
						$time, got.predicted_taken, got.chose_global);
				end else begin
					want = predictions_due.pop_front();
					if (got.predicted_taken != want.predicted_taken) begin
						mismatches++;
						$display("%0t: predicted_taken expected %b actual %b",
							$time, want.predicted_taken, got.predicted_taken);
					end
					if (got.chose_global != want.chose_global) begin
						mismatches++;
						$display("%0t: chose_global expected %b actual %b",
							$time, want.chose_global, got.chose_global);
					end
				end
			end
		end
		outstanding = predictions_due.size();
	end

endmodule

// ===== bench/tournament_branch_predictor_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core_tb
// stream bench for the tournament branch predictor
// ----------------------------------------------------------------------------
// Feeds resolved branches: a short directed run over pc extremes, aliasing
// pcs and saturating counters, then random traffic built mostly from loop
// and correlated branches so the choice counters really move. Both sides
// idle in random bursts; the receiver also stalls once for a long stretch
// so the pipeline backs up. Checking lives in the scoreboard module.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core_tb
	import tbp_pkg::*;
();

	localparam int GHB            = 12;
	localparam int LIB            = 10;
	localparam int LHB            = 11;
	localparam int RANDOM_BRANCHES = 1200;
	localparam int CALM_TAIL      = 150;   // last branches sent with no idling
	localparam int HOLD_AT        = 300;   // branches sent before the long stall
	localparam int HOLD_CYCLES    = 600;
	localparam int STALL_LIMIT    = 20000; // covers the clearing pass
	localparam int POOL_N         = 8;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int mismatches;
	int outstanding;
	int sent = 0;           // accepted input transfers so far
	int send_idle_pct = 0;  // odds of a sender gap before a branch
	int recv_idle_pct = 0;  // odds of a receiver stall burst
	bit calm = 1'b0;        // tail of the run: no idling at all

	tournament_branch_predictor_core #(
		.GLOBAL_HISTORY_BITS(GHB),
		.LOCAL_INDEX_BITS   (LIB),
		.LOCAL_HISTORY_BITS (LHB)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	tournament_branch_predictor_core_chk #(
		.GHB(GHB),
		.LIB(LIB),
		.LHB(LHB)
	) scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one branch transfer; entered and left at a falling edge
	task automatic send_branch(input logic [PC_W-1:0] pc, input logic tk);
		if (!calm && send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tdata <= {{(IN_TDATA_W-PC_W-1){1'b0}}, tk, pc};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		@(negedge clk);
	endtask

	// receiver: random stall bursts, one long hold-off once traffic is going
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && sent >= HOLD_AT) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!calm && recv_idle_pct != 0 &&
				$urandom_range(0, 99) < recv_idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog: too long with no transfer on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [PC_W-1:0] pool_pc [POOL_N];
		int              trip [POOL_N];   // loop trip count per pool branch
		int              iter [POOL_N];
		logic [PC_W-1:0] corr_pc;
		logic [PC_W-1:0] pc;
		logic            tk;
		logic            last_tk;
		int              k, pick;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: pc extremes, counters driven to both rails back to back,
		// pcs that differ only above the local index bits
		send_branch(32'h0000_0000, 1'b0);
		repeat (4) send_branch(32'h0000_0000, 1'b1);
		repeat (4) send_branch(32'hFFFF_FFFF, 1'b1);
		repeat (5) send_branch(32'hFFFF_FFFF, 1'b0);
		send_branch(32'hFFFF_FC00, 1'b1);
		send_branch(32'h0000_03FF, 1'b0);
		send_branch(32'h8000_0001, 1'b1);
		send_branch(32'h0000_0001, 1'b1);
		send_branch(32'h7FFF_FFFE, 1'b0);
		send_branch(32'hAAAA_AAAA, 1'b1);
		send_branch(32'h5555_5555, 1'b0);

		for (int i = 0; i < POOL_N; i++) begin
			pool_pc[i] = $urandom();
			trip[i] = $urandom_range(2, 9);
			iter[i] = 0;
		end
		corr_pc = $urandom();
		last_tk = 1'b0;

		for (k = 0; k < RANDOM_BRANCHES; k++) begin
			// new idling mix every 64 branches, some stretches with none
			if (k % 64 == 0) begin
				case ($urandom_range(0, 4))
					0, 1: begin
						send_idle_pct = 0;
						recv_idle_pct = 0;
					end
					2: begin
						send_idle_pct = 5;
						recv_idle_pct = 5;
					end
					3: begin
						send_idle_pct = 20;
						recv_idle_pct = 40;
					end
					default: begin
						send_idle_pct = 50;
						recv_idle_pct = 15;
					end
				endcase
			end
			if (k >= RANDOM_BRANCHES - CALM_TAIL) calm = 1'b1;

			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// loop branch: taken until the trip count wraps
				pick = $urandom_range(0, POOL_N - 1);
				pc = pool_pc[pick];
				iter[pick]++;
				tk = (iter[pick] % trip[pick] != 0);
			end else if (pick < 75) begin
				// follows the previous outcome, only global history sees it
				pc = corr_pc;
				tk = last_tk;
			end else if (pick < 85) begin
				// aliases a pool branch in the local history table
				pc = {(PC_W-LIB)'($urandom_range(0, 2**(PC_W-LIB) - 1)),
					pool_pc[$urandom_range(0, POOL_N - 1)][LIB-1:0]};
				tk = 1'($urandom_range(0, 1));
			end else begin
				pc = $urandom();
				tk = 1'($urandom_range(0, 1));
			end
			send_branch(pc, tk);
			last_tk = tk;
		end
		s_axis_tvalid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/tbp_pkg.sv
sv/tbp_ram.sv
sv/tournament_branch_predictor_core.sv
bench/tournament_branch_predictor_core_chk.sv
bench/tournament_branch_predictor_core_tb.sv
